// ===== design/apst_pkg.sv =====
// ----------------------------------------------------------------------------
// apst_pkg
// Operation and status codes and the entry layout of the signal table.
// ----------------------------------------------------------------------------
package apst_pkg;

   // operation codes
   localparam logic [3:0] OP_INSERT    = 4'd0;
   localparam logic [3:0] OP_FIND      = 4'd1;
   localparam logic [3:0] OP_BEST_EXC  = 4'd2;
   localparam logic [3:0] OP_BEST_NET  = 4'd3;
   localparam logic [3:0] OP_LIST_NET  = 4'd4;
   localparam logic [3:0] OP_DROP_NET  = 4'd5;
   localparam logic [3:0] OP_DROP_ADDR = 4'd6;
   localparam logic [3:0] OP_KEEP_NET  = 4'd7;
   localparam logic [3:0] OP_READ_SLOT = 4'd8;

   // result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_DUPLICATE = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_RANGE     = 3'd4;

   // most words a single list request may give
   localparam logic [5:0] LIST_MAX = 6'd32;

   // one table entry
   typedef struct packed {
      logic [47:0]        addr;
      logic [63:0]        tag;
      logic signed [7:0]  sig;
      logic [15:0]        mhz;
      logic               open;
   } entry_type;

endpackage

// ===== design/access_point_signal_table.sv =====
// ----------------------------------------------------------------------------
// access_point_signal_table
// Ordered, compacted table of scanned access points held in one memory.
// ----------------------------------------------------------------------------
// Usage:
// A request word (req_ channel) carries one operation; it is taken when
// req_valid is high and req_stall low. req_stall stays high while an
// operation is in progress, so one operation is worked at a time.
// Every operation returns one word on the rsp_ channel, except a network
// list with matches, which returns one word per matching entry up to
// LIST_MAX, the final one flagged by rsp_last_item. rsp_valid holds, with
// its word unchanged, while rsp_stall is high; a stalled list pauses its
// scan until the word is taken. The entries sit in one single-port-read
// memory, one entry read a cycle while no list word is stalled. The next
// request can be taken in the cycle after the final word is loaded.
// Removals write the survivors back in the same pass.
// Reset empties the table (fill count to zero); the memory itself is not
// cleared, as entries beyond the fill count are never read.
// ----------------------------------------------------------------------------
module access_point_signal_table
   import apst_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_operation,
   input  logic [47:0]        req_addr_key,
   input  logic [63:0]        req_network_tag,
   input  logic signed [7:0]  req_signal_dbm,
   input  logic [15:0]        req_channel_mhz,
   input  logic               req_open_flag,
   input  logic [4:0]         req_slot,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_result_status,
   output logic [4:0]         rsp_entry_slot,
   output logic [47:0]        rsp_entry_addr,
   output logic [63:0]        rsp_entry_tag,
   output logic signed [7:0]  rsp_entry_signal,
   output logic [15:0]        rsp_entry_mhz,
   output logic               rsp_entry_open,
   output logic [5:0]         rsp_entry_count,
   output logic               rsp_last_item
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int FW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_LIST, S_RSLOT, S_RDATA, S_DONE
   } state_type;

   state_type         state_ff;
   logic [3:0]        op_ff;
   entry_type         req_ff;
   logic [4:0]        slot_ff;
   logic [FW-1:0]     fill_ff;
   logic [FW-1:0]     scan_ff;
   logic              pend_ff;
   logic [IW-1:0]     pidx_ff;
   logic [FW-1:0]     wr_ff;
   logic              hit_ff;
   logic [IW-1:0]     hit_idx_ff;
   entry_type         hit_ent_ff;
   logic [5:0]        total_ff;
   logic [5:0]        nout_ff;
   logic              removed_ff;
   entry_type         rd_ff;

   logic              rsp_valid_ff;
   logic [2:0]        rsp_status_ff;
   logic [4:0]        rsp_slot_ff;
   entry_type         rsp_ent_ff;
   logic [5:0]        rsp_count_ff;
   logic              rsp_last_ff;

   entry_type         mem [TABLE_DEPTH];

   logic              out_free;
   logic              advance;
   logic              scanning;
   logic              issue;
   logic              chk;
   logic              scan_end;
   logic              addr_eq;
   logic              tag_eq;
   logic              drop;
   logic              is_compact;
   logic              full;
   logic              best_ok;
   logic              list_word;
   logic              rsp_load;
   logic              mem_we;
   logic [IW-1:0]     mem_wa;
   entry_type         mem_wd;
   logic              mem_re;
   logic [IW-1:0]     mem_ra;

   logic [2:0]        fin_status;
   logic              fin_has;
   logic [IW-1:0]     fin_idx;
   entry_type         fin_ent;
   logic [FW-1:0]     fin_count;

   // handshake and scan control
   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      advance    = (state_ff != S_LIST) || out_free;
      scanning   = (state_ff == S_SCAN) || (state_ff == S_LIST);
      issue      = scanning && advance && (scan_ff < fill_ff);
      chk        = scanning && advance && pend_ff;
      scan_end   = scanning && !(scan_ff < fill_ff) && !pend_ff;
      addr_eq    = rd_ff.addr == req_ff.addr;
      tag_eq     = rd_ff.tag == req_ff.tag;
      is_compact = (op_ff == OP_DROP_NET) || (op_ff == OP_DROP_ADDR)
                   || (op_ff == OP_KEEP_NET);
      full       = fill_ff == FW'(TABLE_DEPTH);
      best_ok    = (op_ff == OP_BEST_EXC) ? !addr_eq : tag_eq;
      list_word  = (state_ff == S_LIST) && chk && tag_eq && (nout_ff < total_ff);
      rsp_load   = list_word || ((state_ff == S_DONE) && out_free);
      case (op_ff)
         OP_DROP_NET:  drop = tag_eq;
         OP_KEEP_NET:  drop = !tag_eq;
         OP_DROP_ADDR: drop = addr_eq;
         default:      drop = 1'b0;
      endcase
   end

   // memory port selection
   always_comb begin
      mem_re = issue || (state_ff == S_RSLOT);
      mem_ra = (state_ff == S_RSLOT) ? IW'(slot_ff) : scan_ff[IW-1:0];
      if (state_ff == S_DONE) begin
         mem_we = out_free && (op_ff == OP_INSERT) && !hit_ff && !full;
         mem_wa = fill_ff[IW-1:0];
         mem_wd = req_ff;
      end else begin
         mem_we = chk && (state_ff == S_SCAN) && is_compact && !drop;
         mem_wa = wr_ff[IW-1:0];
         mem_wd = rd_ff;
      end
   end

   // entry memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_ra];
      end
   end

   // final word of a single-word operation
   always_comb begin
      fin_has    = 1'b0;
      fin_idx    = hit_idx_ff;
      fin_ent    = hit_ent_ff;
      fin_count  = fill_ff;
      fin_status = ST_NOT_FOUND;
      case (op_ff)
         OP_INSERT: begin
            if (hit_ff) begin
               fin_status = ST_DUPLICATE;
               fin_has    = 1'b1;
            end else if (full) begin
               fin_status = ST_FULL;
            end else begin
               fin_status = ST_OK;
               fin_has    = 1'b1;
               fin_idx    = fill_ff[IW-1:0];
               fin_ent    = req_ff;
               fin_count  = fill_ff + FW'(1);
            end
         end
         OP_FIND, OP_BEST_EXC, OP_BEST_NET: begin
            fin_status = hit_ff ? ST_OK : ST_NOT_FOUND;
            fin_has    = hit_ff;
         end
         OP_READ_SLOT: begin
            fin_status = hit_ff ? ST_OK : ST_RANGE;
            fin_has    = hit_ff;
         end
         OP_DROP_NET, OP_DROP_ADDR: begin
            fin_status = removed_ff ? ST_OK : ST_NOT_FOUND;
         end
         OP_KEEP_NET: begin
            fin_status = ST_OK;
         end
         default: begin
            fin_status = ST_NOT_FOUND;
         end
      endcase
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         if (issue) begin
            pidx_ff <= scan_ff[IW-1:0];
            scan_ff <= scan_ff + FW'(1);
         end
         if (advance && scanning) begin
            pend_ff <= issue;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff       <= req_operation;
                  req_ff.addr <= req_addr_key;
                  req_ff.tag  <= req_network_tag;
                  req_ff.sig  <= req_signal_dbm;
                  req_ff.mhz  <= req_channel_mhz;
                  req_ff.open <= req_open_flag;
                  slot_ff     <= req_slot;
                  hit_ff      <= 1'b0;
                  scan_ff     <= '0;
                  pend_ff     <= 1'b0;
                  wr_ff       <= '0;
                  total_ff    <= '0;
                  nout_ff     <= '0;
                  removed_ff  <= 1'b0;
                  if (req_operation <= OP_KEEP_NET) begin
                     state_ff <= S_SCAN;
                  end else if (req_operation == OP_READ_SLOT &&
                               7'(req_slot) < 7'(fill_ff)) begin
                     state_ff <= S_RSLOT;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_SCAN: begin
               if (chk) begin
                  case (op_ff)
                     OP_INSERT, OP_FIND: begin
                        if (addr_eq && !hit_ff) begin
                           hit_ff     <= 1'b1;
                           hit_idx_ff <= pidx_ff;
                           hit_ent_ff <= rd_ff;
                        end
                     end
                     OP_BEST_EXC, OP_BEST_NET: begin
                        if (best_ok && (!hit_ff || rd_ff.sig > hit_ent_ff.sig)) begin
                           hit_ff     <= 1'b1;
                           hit_idx_ff <= pidx_ff;
                           hit_ent_ff <= rd_ff;
                        end
                     end
                     OP_LIST_NET: begin
                        if (tag_eq && total_ff < LIST_MAX) begin
                           total_ff <= total_ff + 6'd1;
                        end
                     end
                     default: begin
                        if (drop) begin
                           removed_ff <= 1'b1;
                        end else begin
                           wr_ff <= wr_ff + FW'(1);
                        end
                     end
                  endcase
               end
               if (scan_end) begin
                  if (is_compact) begin
                     fill_ff <= wr_ff;
                  end
                  if (op_ff == OP_LIST_NET && total_ff != 6'd0) begin
                     scan_ff  <= '0;
                     state_ff <= S_LIST;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_LIST: begin
               if (list_word) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= ST_OK;
                  rsp_slot_ff   <= 5'(pidx_ff);
                  rsp_ent_ff    <= rd_ff;
                  rsp_count_ff  <= 6'(fill_ff);
                  rsp_last_ff   <= (nout_ff + 6'd1) == total_ff;
                  nout_ff       <= nout_ff + 6'd1;
                  if ((nout_ff + 6'd1) == total_ff) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_RSLOT: begin
               state_ff <= S_RDATA;
            end
            S_RDATA: begin
               hit_ff     <= 1'b1;
               hit_idx_ff <= IW'(slot_ff);
               hit_ent_ff <= rd_ff;
               state_ff   <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= fin_status;
                  rsp_slot_ff   <= fin_has ? 5'(fin_idx) : 5'd0;
                  rsp_ent_ff    <= fin_has ? fin_ent : '0;
                  rsp_count_ff  <= 6'(fin_count);
                  rsp_last_ff   <= 1'b1;
                  fill_ff       <= fin_count;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall         = state_ff != S_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_status = rsp_status_ff;
   assign rsp_entry_slot    = rsp_slot_ff;
   assign rsp_entry_addr    = rsp_ent_ff.addr;
   assign rsp_entry_tag     = rsp_ent_ff.tag;
   assign rsp_entry_signal  = rsp_ent_ff.sig;
   assign rsp_entry_mhz     = rsp_ent_ff.mhz;
   assign rsp_entry_open    = rsp_ent_ff.open;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_last_item     = rsp_last_ff;

endmodule

// ===== design/apst_checker.sv =====
// ----------------------------------------------------------------------------
// apst_checker
// Port-level checks on the signal table's result channel.
// ----------------------------------------------------------------------------
module apst_checker
   import apst_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_result_status,
   input logic [4:0]         rsp_entry_slot,
   input logic [47:0]        rsp_entry_addr,
   input logic [63:0]        rsp_entry_tag,
   input logic signed [7:0]  rsp_entry_signal,
   input logic [15:0]        rsp_entry_mhz,
   input logic               rsp_entry_open,
   input logic               rsp_last_item
);

   // a stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_status)
         && $stable(rsp_entry_addr) && $stable(rsp_last_item))
      else $error("stalled result word changed");

   // status codes stay in range
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_status <= ST_RANGE)
      else $error("result status out of range");

   // only list words come without the last flag, and they report an entry
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_item |-> rsp_result_status == ST_OK)
      else $error("non-final word with failing status");

   // not-found, full and range results report no entry
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_status == ST_NOT_FOUND || rsp_result_status == ST_FULL
         || rsp_result_status == ST_RANGE)
      |-> rsp_entry_slot == 5'd0 && rsp_entry_addr == 48'd0 && rsp_entry_tag == 64'd0
         && rsp_entry_signal == 8'sd0 && rsp_entry_mhz == 16'd0 && !rsp_entry_open)
      else $error("entry fields set on failing result");

endmodule

bind access_point_signal_table apst_checker u_apst_checker (.*);
